// ----- hdl/lghm_pkg.sv -----
// ============================================================================
// lghm_pkg: shared types and constants for the lattice gas hop unit
// Beat formats, controller/datapath command and status, register indexes
// and the hexagonal neighbour offsets.
// ============================================================================
package lghm_pkg;

    localparam int GRID_SIDE_DEF  = 48;
    localparam int ATOM_COUNT_DEF = 768;
    localparam int PROB_BITS_DEF  = 16;

    localparam int COORD_W     = 6;
    localparam int IDX_W       = 10;
    localparam int DIRECTION_W = 3;
    localparam int RND_W       = 16;
    localparam int THR_W       = 16;
    localparam int THR_COUNT   = 5;
    localparam int CHANGE_W    = 4;
    localparam int TOTAL_W     = 32;
    localparam int COUNT_W     = 3;
    localparam int STEP_W      = 4;
    localparam int DIR_COUNT   = 6;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Scan steps: the target site first, then the origin ring, then the target ring.
    localparam logic [STEP_W-1:0] STEP_TARGET      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_ORIGIN_LAST = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LAST        = 4'd12;

    typedef enum logic [DIRECTION_W-1:0] {
        HOP_SW = 3'd0,
        HOP_S  = 3'd1,
        HOP_E  = 3'd2,
        HOP_NE = 3'd3,
        HOP_N  = 3'd4,
        HOP_W  = 3'd5
    } t_dir;

    typedef enum logic [1:0] {
        DELTA_NONE = 2'd0,
        DELTA_DEC  = 2'd1,
        DELTA_INC  = 2'd2
    } t_delta;

    typedef enum logic [2:0] {
        REG_THR1 = 3'd0,
        REG_THR2 = 3'd1,
        REG_THR3 = 3'd2,
        REG_THR4 = 3'd3,
        REG_THR5 = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_POS,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_MOVE_FROM,
        S_MOVE_TO,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]       atom_index;
        logic [DIRECTION_W-1:0] direction;
        logic [RND_W-1:0]       random_fraction;
    } t_hop_in;

    typedef struct packed {
        logic                       accepted;
        logic                       blocked;
        logic [COORD_W-1:0]         from_x;
        logic [COORD_W-1:0]         from_y;
        logic [COORD_W-1:0]         to_x;
        logic [COORD_W-1:0]         to_y;
        logic signed [CHANGE_W-1:0] neighbour_change;
        logic [TOTAL_W-1:0]         move_total;
        logic [TOTAL_W-1:0]         reject_total;
    } t_hop_out;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_pos;

    typedef struct packed {
        logic              init_step;
        logic              start;
        logic              pos_rd;
        logic              pos_latch;
        logic              scan_rd;
        logic [STEP_W-1:0] scan_step;
        logic              decide;
        logic              move_from;
        logic              move_to;
        logic              load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic placed_ok;
        logic dir_ok;
        logic blocked;
        logic accept;
        logic out_free;
    } t_dp_sts;

    function automatic t_delta f_hop_dx(input logic [DIRECTION_W-1:0] dir);
        t_delta d;
        case (t_dir'(dir))
            HOP_SW: d = DELTA_DEC;
            HOP_E:  d = DELTA_INC;
            HOP_NE: d = DELTA_INC;
            HOP_W:  d = DELTA_DEC;
            default: d = DELTA_NONE;
        endcase
        return d;
    endfunction

    function automatic t_delta f_hop_dy(input logic [DIRECTION_W-1:0] dir);
        t_delta d;
        case (t_dir'(dir))
            HOP_SW: d = DELTA_DEC;
            HOP_S:  d = DELTA_DEC;
            HOP_NE: d = DELTA_INC;
            HOP_N:  d = DELTA_INC;
            default: d = DELTA_NONE;
        endcase
        return d;
    endfunction

    function automatic logic [COORD_W-1:0] f_wrap(
        input logic [COORD_W-1:0] c,
        input t_delta             d,
        input logic [COORD_W-1:0] last
    );
        logic [COORD_W-1:0] r;
        case (d)
            DELTA_DEC: r = (c == '0) ? last : c - COORD_W'(1);
            DELTA_INC: r = (c == last) ? '0 : c + COORD_W'(1);
            default:   r = c;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/lghm_regs.sv -----
// ============================================================================
// lghm_regs: acceptance threshold registers
// APB-style register file holding the five acceptance thresholds.
// ============================================================================
module lghm_regs (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_psel,
    input  logic                                                i_penable,
    input  logic                                                i_pwrite,
    input  logic [lghm_pkg::APB_ADDR_W-1:0]                     i_paddr,
    input  logic [lghm_pkg::APB_DATA_W-1:0]                     i_pwdata,
    output logic [lghm_pkg::APB_DATA_W-1:0]                     o_prdata,
    output logic [lghm_pkg::THR_COUNT-1:0][lghm_pkg::THR_W-1:0] o_thr
);
    import lghm_pkg::*;

    logic [THR_COUNT-1:0][THR_W-1:0] r_thr;
    logic [2:0]                      reg_sel;
    logic                            wr_en;
    logic [THR_W-1:0]                rd_val;

    assign reg_sel = i_paddr[4:2];
    assign wr_en   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '1;
        end else if (wr_en) begin
            case (t_reg'(reg_sel))
                REG_THR1: r_thr[0] <= i_pwdata[THR_W-1:0];
                REG_THR2: r_thr[1] <= i_pwdata[THR_W-1:0];
                REG_THR3: r_thr[2] <= i_pwdata[THR_W-1:0];
                REG_THR4: r_thr[3] <= i_pwdata[THR_W-1:0];
                REG_THR5: r_thr[4] <= i_pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(reg_sel))
            REG_THR1: rd_val = r_thr[0];
            REG_THR2: rd_val = r_thr[1];
            REG_THR3: rd_val = r_thr[2];
            REG_THR4: rd_val = r_thr[3];
            REG_THR5: rd_val = r_thr[4];
            default:  rd_val = '0;
        endcase
    end

    assign o_prdata = APB_DATA_W'(rd_val);
    assign o_thr    = r_thr;

endmodule

// ----- hdl/lghm_ctrl.sv -----
// ============================================================================
// lghm_ctrl: hop sequencer
// State machine that runs the reset fill, the position lookup, the
// thirteen-read occupancy scan, the decision, the write-back and the result.
// ============================================================================
module lghm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lghm_pkg::t_dp_sts i_sts,
    output lghm_pkg::t_dp_cmd o_cmd,
    output logic              o_in_stall
);
    import lghm_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign n_step = (r_state == S_SCAN) ? r_step + STEP_W'(1) : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:      if (i_sts.init_last) n_state = S_IDLE;
            S_IDLE:      if (i_in_valid) n_state = S_CHECK;
            S_CHECK:     n_state = i_sts.placed_ok ? S_POS : S_RESULT;
            S_POS:       n_state = i_sts.dir_ok ? S_SCAN : S_RESULT;
            S_SCAN:      if (r_step == STEP_LAST) n_state = S_DRAIN;
            S_DRAIN:     n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = (!i_sts.blocked && i_sts.accept) ? S_MOVE_FROM : S_RESULT;
            end
            S_MOVE_FROM: n_state = S_MOVE_TO;
            S_MOVE_TO:   n_state = S_RESULT;
            S_RESULT:    if (i_sts.out_free) n_state = S_IDLE;
            default:     n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.scan_step = r_step;
        o_in_stall      = 1'b1;
        case (r_state)
            S_INIT:      o_cmd.init_step = 1'b1;
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid;
            end
            S_CHECK:     o_cmd.pos_rd = i_sts.placed_ok;
            S_POS:       o_cmd.pos_latch = 1'b1;
            S_SCAN:      o_cmd.scan_rd = 1'b1;
            S_DECIDE:    o_cmd.decide = 1'b1;
            S_MOVE_FROM: o_cmd.move_from = 1'b1;
            S_MOVE_TO:   o_cmd.move_to = 1'b1;
            S_RESULT:    o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ----- hdl/lghm_datapath.sv -----
// ============================================================================
// lghm_datapath: lattice storage and hop arithmetic
// Occupancy and position memories, the reset pattern fill, neighbour counts,
// the acceptance test, the move counters and the result register.
// ============================================================================
module lghm_datapath #(
    parameter int GRID_SIDE  = lghm_pkg::GRID_SIDE_DEF,
    parameter int ATOM_COUNT = lghm_pkg::ATOM_COUNT_DEF,
    parameter int PROB_BITS  = lghm_pkg::PROB_BITS_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  lghm_pkg::t_dp_cmd                                   i_cmd,
    input  lghm_pkg::t_hop_in                                   i_in_data,
    input  logic [lghm_pkg::THR_COUNT-1:0][lghm_pkg::THR_W-1:0] i_thr,
    input  logic                                                i_out_stall,
    output lghm_pkg::t_dp_sts                                   o_sts,
    output logic                                                o_out_valid,
    output lghm_pkg::t_hop_out                                  o_out_data
);
    import lghm_pkg::*;

    localparam int SITE_TOTAL = GRID_SIDE * GRID_SIDE;
    localparam int SITE_W     = $clog2(SITE_TOTAL);
    localparam int ATOM_W     = $clog2(ATOM_COUNT);
    localparam int PLACED_W   = $clog2(ATOM_COUNT + 1);
    localparam int CMP_W      = (PLACED_W > IDX_W) ? PLACED_W : IDX_W;
    localparam int PROB_KEEP  = (PROB_BITS < RND_W) ? PROB_BITS : RND_W;
    localparam logic [RND_W-1:0]   PROB_MASK = RND_W'((33'd1 << PROB_KEEP) - 33'd1);
    localparam logic [COORD_W-1:0] LAST      = COORD_W'(GRID_SIDE - 1);
    localparam logic [SITE_W-1:0]  SIDE_C    = SITE_W'(GRID_SIDE);
    localparam logic [SITE_W-1:0]  SITE_END  = SITE_W'(SITE_TOTAL - 1);

    function automatic logic [SITE_W-1:0] f_site(input t_pos p);
        return SITE_W'(p.y) * SIDE_C + SITE_W'(p.x);
    endfunction

    logic site_mem [SITE_TOTAL];
    t_pos pos_mem  [ATOM_COUNT];

    // Reset fill walk
    logic [SITE_W-1:0]   r_init_addr;
    logic [COORD_W-1:0]  r_init_x;
    logic [COORD_W-1:0]  r_init_y;
    logic [1:0]          r_init_phase;
    logic [1:0]          r_row_phase;
    logic [PLACED_W-1:0] r_placed;
    logic                init_occ;

    // Item state
    logic [IDX_W-1:0]           r_idx;
    logic [DIRECTION_W-1:0]     r_dir;
    logic [RND_W-1:0]           r_rnd;
    t_pos                       r_from;
    t_pos                       r_to;
    t_pos                       r_pos_q;
    logic                       r_site_q;
    logic                       r_rd_vld;
    logic [STEP_W-1:0]          r_rd_step;
    logic [COUNT_W-1:0]         r_here;
    logic [COUNT_W-1:0]         r_there;
    logic                       r_blk;
    logic                       r_acc;
    logic                       r_tried;
    logic signed [CHANGE_W-1:0] r_change;
    logic [TOTAL_W-1:0]         r_moves;
    logic [TOTAL_W-1:0]         r_rejects;
    logic                       r_out_valid;
    t_hop_out                   r_out;

    t_pos                       hop_to;
    t_pos                       scan_base;
    t_pos                       scan_pos;
    logic [DIRECTION_W-1:0]     scan_dir;
    logic [SITE_W-1:0]          site_addr;
    logic                       site_we;
    logic                       site_wd;
    logic                       pos_we;
    logic [ATOM_W-1:0]          pos_wa;
    t_pos                       pos_wd;
    logic signed [CHANGE_W-1:0] change_c;
    logic [THR_W-1:0]           thr_sel;
    logic                       accept_c;
    logic                       out_free;
    logic [TOTAL_W-1:0]         n_moves;
    logic [TOTAL_W-1:0]         n_rejects;

    assign init_occ = (r_init_phase == 2'd0) && (r_placed < PLACED_W'(ATOM_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_addr  <= '0;
            r_init_x     <= '0;
            r_init_y     <= '0;
            r_init_phase <= 2'd0;
            r_row_phase  <= 2'd0;
            r_placed     <= '0;
        end else if (i_cmd.init_step) begin
            r_init_addr <= r_init_addr + SITE_W'(1);
            if (init_occ) begin
                r_placed <= r_placed + PLACED_W'(1);
            end
            if (r_init_x == LAST) begin
                r_init_x     <= '0;
                r_init_y     <= r_init_y + COORD_W'(1);
                r_row_phase  <= (r_row_phase == 2'd2) ? 2'd0 : r_row_phase + 2'd1;
                r_init_phase <= (r_row_phase == 2'd2) ? 2'd0 : r_row_phase + 2'd1;
            end else begin
                r_init_x     <= r_init_x + COORD_W'(1);
                r_init_phase <= (r_init_phase == 2'd2) ? 2'd0 : r_init_phase + 2'd1;
            end
        end
    end

    assign hop_to.x = f_wrap(r_pos_q.x, f_hop_dx(r_dir), LAST);
    assign hop_to.y = f_wrap(r_pos_q.y, f_hop_dy(r_dir), LAST);

    always_comb begin
        if (i_cmd.scan_step == STEP_TARGET) begin
            scan_base = r_from;
            scan_dir  = r_dir;
        end else if (i_cmd.scan_step <= STEP_ORIGIN_LAST) begin
            scan_base = r_from;
            scan_dir  = DIRECTION_W'(i_cmd.scan_step - STEP_W'(1));
        end else begin
            scan_base = r_to;
            scan_dir  = DIRECTION_W'(i_cmd.scan_step - STEP_ORIGIN_LAST - STEP_W'(1));
        end
    end

    assign scan_pos.x = f_wrap(scan_base.x, f_hop_dx(scan_dir), LAST);
    assign scan_pos.y = f_wrap(scan_base.y, f_hop_dy(scan_dir), LAST);

    always_comb begin
        site_we   = 1'b0;
        site_wd   = 1'b0;
        site_addr = f_site(scan_pos);
        if (i_cmd.init_step) begin
            site_we   = 1'b1;
            site_wd   = init_occ;
            site_addr = r_init_addr;
        end else if (i_cmd.move_from) begin
            site_we   = 1'b1;
            site_addr = f_site(r_from);
        end else if (i_cmd.move_to) begin
            site_we   = 1'b1;
            site_wd   = 1'b1;
            site_addr = f_site(r_to);
        end
    end

    always_ff @(posedge i_clk) begin
        if (site_we) begin
            site_mem[site_addr] <= site_wd;
        end
        if (i_cmd.scan_rd) begin
            r_site_q <= site_mem[site_addr];
        end
    end

    assign pos_we   = (i_cmd.init_step && init_occ) || i_cmd.move_from;
    assign pos_wa   = i_cmd.init_step ? ATOM_W'(r_placed) : ATOM_W'(r_idx);
    assign pos_wd.x = i_cmd.init_step ? r_init_x : r_to.x;
    assign pos_wd.y = i_cmd.init_step ? r_init_y : r_to.y;

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (i_cmd.pos_rd) begin
            r_pos_q <= pos_mem[ATOM_W'(r_idx)];
        end
    end

    assign change_c = CHANGE_W'(r_there) - CHANGE_W'(1) - CHANGE_W'(r_here);

    always_comb begin
        case (change_c)
            4'sd1:   thr_sel = i_thr[0];
            4'sd2:   thr_sel = i_thr[1];
            4'sd3:   thr_sel = i_thr[2];
            4'sd4:   thr_sel = i_thr[3];
            4'sd5:   thr_sel = i_thr[4];
            default: thr_sel = '0;
        endcase
    end

    assign accept_c = (change_c <= 4'sd0) || ((r_rnd & PROB_MASK) <= (thr_sel & PROB_MASK));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx    <= i_in_data.atom_index;
            r_dir    <= i_in_data.direction;
            r_rnd    <= i_in_data.random_fraction;
            r_from   <= '0;
            r_to     <= '0;
            r_here   <= '0;
            r_there  <= '0;
            r_blk    <= 1'b0;
            r_acc    <= 1'b0;
            r_tried  <= 1'b0;
            r_change <= '0;
        end else begin
            if (i_cmd.pos_latch) begin
                r_from <= r_pos_q;
                r_to   <= hop_to;
            end
            if (r_rd_vld) begin
                if (r_rd_step == STEP_TARGET) begin
                    r_blk <= r_site_q;
                end else if (r_rd_step <= STEP_ORIGIN_LAST) begin
                    r_here <= r_here + COUNT_W'(r_site_q);
                end else begin
                    r_there <= r_there + COUNT_W'(r_site_q);
                end
            end
            if (i_cmd.decide) begin
                r_tried  <= 1'b1;
                r_acc    <= !r_blk && accept_c;
                r_change <= r_blk ? '0 : change_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_step <= i_cmd.scan_step;
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign n_moves   = r_moves + TOTAL_W'(r_acc);
    assign n_rejects = r_rejects + TOTAL_W'(r_tried && !r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moves     <= '0;
            r_rejects   <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_moves     <= n_moves;
            r_rejects   <= n_rejects;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.accepted         <= r_acc;
            r_out.blocked          <= r_blk && r_tried;
            r_out.from_x           <= r_from.x;
            r_out.from_y           <= r_from.y;
            r_out.to_x             <= r_to.x;
            r_out.to_y             <= r_to.y;
            r_out.neighbour_change <= r_change;
            r_out.move_total       <= n_moves;
            r_out.reject_total     <= n_rejects;
        end
    end

    assign o_sts.init_last = i_cmd.init_step && (r_init_addr == SITE_END);
    assign o_sts.placed_ok = CMP_W'(r_idx) < CMP_W'(r_placed);
    assign o_sts.dir_ok    = r_dir < DIRECTION_W'(DIR_COUNT);
    assign o_sts.blocked   = r_blk;
    assign o_sts.accept    = accept_c;
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/lattice_gas_hop_metropolis_unit.sv -----
// ============================================================================
// lattice_gas_hop_metropolis_unit: Metropolis hop on a periodic hex lattice
// An unplaced atom or a bad direction goes to the result without the scan; a
// blocked or rejected hop skips the write-back that an accepted hop makes.
// One item at a time; the next beat is taken once the result is registered.
// The 13 single-port occupancy reads of the neighbour scan set the rate.
// After reset the lattice is filled site by site, stall high.
// ============================================================================
module lattice_gas_hop_metropolis_unit #(
    parameter int GRID_SIDE  = lghm_pkg::GRID_SIDE_DEF,
    parameter int ATOM_COUNT = lghm_pkg::ATOM_COUNT_DEF,
    parameter int PROB_BITS  = lghm_pkg::PROB_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lghm_pkg::t_hop_in                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lghm_pkg::t_hop_out                  o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lghm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lghm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lghm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import lghm_pkg::*;

    logic [THR_COUNT-1:0][THR_W-1:0] thr;
    t_dp_cmd                         cmd;
    t_dp_sts                         sts;

    assign pready = 1'b1;

    lghm_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_thr     (thr)
    );

    lghm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lghm_datapath #(
        .GRID_SIDE  (GRID_SIDE),
        .ATOM_COUNT (ATOM_COUNT),
        .PROB_BITS  (PROB_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_thr       (thr),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/lghm_checker.sv -----
// ============================================================================
// lghm_checker: port-level checks for the lattice gas hop unit
// Watches the handshakes and result beats of the top level.
// ============================================================================
module lghm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lghm_pkg::t_hop_out o_out_data
);
    import lghm_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    a_blocked_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.blocked |->
            !o_out_data.accepted && o_out_data.neighbour_change == '0)
        else $error("blocked beat shows a move or a neighbour change");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted |->
            (o_out_data.from_x != o_out_data.to_x) ||
            (o_out_data.from_y != o_out_data.to_y))
        else $error("accepted beat with target equal to origin");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

endmodule

bind lattice_gas_hop_metropolis_unit lghm_checker u_chk (.*);
